>>> rtl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the power sequencer
// Phase codes, flag and pin positions, retention codes, LED pattern tables
// and the payload structures of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
package aps_pkg;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_INIT       = 3'd1,
    PH_MONITOR    = 3'd2,
    PH_POWER_ON   = 3'd3,
    PH_WAIT_GOOD  = 3'd4,
    PH_RESET_HOLD = 3'd5,
    PH_OFF        = 3'd6,
    PH_PULSE      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    AL_OFF     = 3'd0,
    AL_UP      = 3'd1,
    AL_FAIL    = 3'd2,
    AL_PENDING = 3'd3,
    AL_ON      = 3'd4
  } alert_t;

  localparam int FL_PWR_REQ  = 0;
  localparam int FL_OVERRIDE = 1;
  localparam int FL_RST_REQ  = 2;
  localparam int FL_COORD    = 3;
  localparam int FL_FAULT    = 4;
  localparam int FL_WATCH    = 5;

  localparam int PIN_SUPPLY = 0;
  localparam int PIN_RESET  = 1;
  localparam int PIN_REQ    = 2;

  localparam logic [1:0] RETAIN_NONE     = 2'd0;
  localparam logic [1:0] RETAIN_OFF_CODE = 2'd1;
  localparam logic [1:0] RETAIN_ON_CODE  = 2'd2;

  localparam logic [7:0] LEN_UP   = 8'd100;
  localparam logic [7:0] LEN_FAIL = 8'd150;

  localparam int CFG_DEBOUNCE  = 0;
  localparam int CFG_OVERRIDE  = 1;
  localparam int CFG_REQ_MIN   = 2;
  localparam int CFG_REQ_MAX   = 3;
  localparam int CFG_REQ_LIMIT = 4;
  localparam int CFG_PG_TIMEOUT = 5;
  localparam int CFG_RST_HOLD  = 6;
  localparam int CFG_PULSE     = 7;

  typedef struct packed {
    logic power_button;
    logic reset_button;
    logic power_good;
    logic host_request;
    logic store_busy;
    logic retained_on;
  } tick_t;

  typedef struct packed {
    logic       supply_enable;
    logic       system_reset;
    logic       led_on;
    logic       request_drive;
    logic [1:0] retain_write;
    logic       fault_flag;
    logic       is_powered;
    logic [2:0] phase;
  } result_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [9:0] override_ticks;
    logic [7:0] request_min_ticks;
    logic [7:0] request_max_ticks;
    logic [7:0] request_hold_limit;
    logic [9:0] power_good_timeout;
    logic [9:0] reset_hold_ticks;
    logic [9:0] host_pulse_ticks;
  } cfg_t;

  // Blink pattern bit lookup; bytes past the table read as dark.
  function automatic logic rom_up_bit(input logic [7:0] idx);
    logic [7:0] b;
    unique case (idx[7:3])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: b = 8'hff;
      5'd6: b = 8'h03;
      default: b = 8'h00;
    endcase
    return b[idx[2:0]];
  endfunction

  function automatic logic rom_fail_bit(input logic [7:0] idx);
    logic [7:0] b;
    unique case (idx[7:3])
      5'd0, 5'd1, 5'd7: b = 8'hff;
      5'd2: b = 8'h0f;
      5'd6: b = 8'hfc;
      5'd8: b = 8'h3f;
      default: b = 8'h00;
    endcase
    return b[idx[2:0]];
  endfunction

endpackage
`default_nettype wire

>>> rtl/aps_stream_if.sv
// ----------------------------------------------------------------------------
// aps_stream_if: valid/ready channel
// Carries one payload of a chosen type with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none
interface aps_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/aps_cfg_regs.sv
// ----------------------------------------------------------------------------
// aps_cfg_regs: configuration register file
// Eight write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none
module aps_cfg_regs
  import aps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  output cfg_t            cfg
);

  // Registers take their documented reset values and load on a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= 8'd15;
      cfg.override_ticks     <= 10'd400;
      cfg.request_min_ticks  <= 8'd2;
      cfg.request_max_ticks  <= 8'd10;
      cfg.request_hold_limit <= 8'd30;
      cfg.power_good_timeout <= 10'd200;
      cfg.reset_hold_ticks   <= 10'd15;
      cfg.host_pulse_ticks   <= 10'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        3'(CFG_DEBOUNCE):   cfg.debounce_ticks     <= cfg_data[7:0];
        3'(CFG_OVERRIDE):   cfg.override_ticks     <= cfg_data;
        3'(CFG_REQ_MIN):    cfg.request_min_ticks  <= cfg_data[7:0];
        3'(CFG_REQ_MAX):    cfg.request_max_ticks  <= cfg_data[7:0];
        3'(CFG_REQ_LIMIT):  cfg.request_hold_limit <= cfg_data[7:0];
        3'(CFG_PG_TIMEOUT): cfg.power_good_timeout <= cfg_data;
        3'(CFG_RST_HOLD):   cfg.reset_hold_ticks   <= cfg_data;
        default:            cfg.host_pulse_ticks   <= cfg_data;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/aps_tick_core.sv
// ----------------------------------------------------------------------------
// aps_tick_core: per-tick sequencer state and update logic
// Holds all sequencer state and computes one result for each accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none
module aps_tick_core
  import aps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire tick_t tick,
  input  wire cfg_t  cfg,
  output result_t    result
);

  phase_t     seq_phase, seq_phase_next;
  alert_t     alert_mode, alert_mode_next;
  logic [9:0] elapsed, elapsed_next;
  logic       powered, powered_next;
  logic [5:0] flags, flags_next;
  logic       pstable, pstable_next, rstable, rstable_next;
  logic [7:0] pcount, pcount_next, rcount, rcount_next;
  logic [9:0] hold_count, hold_count_next;
  logic       request_last, request_last_next;
  logic [7:0] request_count, request_count_next;
  logic [7:0] pattern_index, pattern_index_next;
  logic [2:0] pins, pins_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase <= PH_START; alert_mode <= AL_OFF; elapsed <= '0; powered <= 1'b0;
      flags <= '0; pstable <= 1'b0; rstable <= 1'b0; pcount <= '0; rcount <= '0;
      hold_count <= '0; request_last <= 1'b0; request_count <= '0;
      pattern_index <= '0; pins <= '0;
    end else if (step) begin
      seq_phase <= seq_phase_next; alert_mode <= alert_mode_next;
      elapsed <= elapsed_next; powered <= powered_next; flags <= flags_next;
      pstable <= pstable_next; rstable <= rstable_next; pcount <= pcount_next;
      rcount <= rcount_next; hold_count <= hold_count_next;
      request_last <= request_last_next; request_count <= request_count_next;
      pattern_index <= pattern_index_next; pins <= pins_next;
    end
  end

  // One tick of the sequence, in the documented order.
  always_comb begin
    logic       led;
    logic [1:0] retain;
    logic [7:0] plen;
    logic [7:0] pinc;
    logic [9:0] el_inc;
    seq_phase_next = seq_phase; alert_mode_next = alert_mode;
    elapsed_next = elapsed; powered_next = powered; flags_next = flags;
    pstable_next = pstable; rstable_next = rstable; pcount_next = pcount;
    rcount_next = rcount; hold_count_next = hold_count;
    request_last_next = request_last; request_count_next = request_count;
    pattern_index_next = pattern_index; pins_next = pins;
    led = 1'b0; retain = RETAIN_NONE;
    plen = 8'd1; pinc = '0;
    el_inc = (elapsed == 10'h3ff) ? elapsed : elapsed + 10'd1;

    if (seq_phase == PH_START) begin
      pstable_next = tick.power_button;
      rstable_next = tick.reset_button;
      if (tick.power_good) begin
        pins_next = 3'b001; seq_phase_next = PH_MONITOR;
      end else begin
        pins_next = 3'b010; seq_phase_next = PH_INIT;
      end
      alert_mode_next = AL_OFF; pattern_index_next = '0;
    end else begin
      // LED pattern playback
      unique case (alert_mode)
        AL_UP, AL_PENDING: begin led = rom_up_bit(pattern_index); plen = LEN_UP; end
        AL_FAIL: begin led = rom_fail_bit(pattern_index); plen = LEN_FAIL; end
        AL_ON: begin led = (pattern_index == 8'd0); plen = 8'd1; end
        default: begin led = 1'b0; plen = 8'd1; end
      endcase
      pinc = pattern_index + 8'd1;
      pattern_index_next = (pinc >= plen) ? 8'd0 : pinc;

      // Loss of power good while watched
      if (flags[FL_WATCH] && !tick.power_good) begin
        flags_next[FL_WATCH] = 1'b0;
        pins_next[PIN_RESET] = 1'b1; pins_next[PIN_SUPPLY] = 1'b0;
        flags_next[FL_FAULT] = 1'b1;
      end

      // Power button debounce and long hold
      if (tick.power_button != pstable) begin
        pcount_next = pcount + 8'd1;
        if (pcount_next >= cfg.debounce_ticks) begin
          if (tick.power_button) flags_next[FL_PWR_REQ] = 1'b1;
          pstable_next = tick.power_button;
          pcount_next = '0; hold_count_next = '0;
          flags_next[FL_OVERRIDE] = 1'b0;
        end
      end else begin
        pcount_next = '0;
      end
      if (pstable_next && tick.power_button && hold_count_next < cfg.override_ticks) begin
        hold_count_next = hold_count_next + 10'd1;
        if (hold_count_next >= cfg.override_ticks) flags_next[FL_OVERRIDE] = 1'b1;
      end

      // Reset button debounce
      if (tick.reset_button != rstable) begin
        rcount_next = rcount + 8'd1;
        if (rcount_next >= cfg.debounce_ticks) begin
          if (tick.reset_button) pins_next[PIN_RESET] = 1'b1;
          else flags_next[FL_RST_REQ] = 1'b1;
          rstable_next = tick.reset_button;
          rcount_next = '0;
        end
      end else begin
        rcount_next = '0;
      end

      // Host request pulse width, measured in monitor only
      if (seq_phase == PH_MONITOR) begin
        if (!request_last && tick.host_request) request_count_next = '0;
        if (request_last && !tick.host_request &&
            request_count_next >= cfg.request_min_ticks &&
            request_count_next <= cfg.request_max_ticks)
          flags_next[FL_COORD] = 1'b1;
        request_last_next = tick.host_request;
        if (!tick.host_request) request_count_next = '0;
        else if (request_count_next <= cfg.request_hold_limit &&
                 request_count_next != 8'hff)
          request_count_next = request_count_next + 8'd1;
      end else begin
        request_count_next = '0;
      end

      // Sequencer phase update
      unique case (seq_phase)
        PH_INIT: seq_phase_next = tick.retained_on ? PH_POWER_ON : PH_OFF;
        PH_MONITOR: begin
          if (flags_next[FL_OVERRIDE] && powered) flags_next[FL_PWR_REQ] = 1'b1;
          if (flags_next[FL_PWR_REQ]) begin
            if (!powered) begin
              seq_phase_next = PH_POWER_ON;
            end else begin
              if (flags_next[FL_COORD] && !flags_next[FL_OVERRIDE]) begin
                pins_next[PIN_REQ] = 1'b1; elapsed_next = '0;
                seq_phase_next = PH_PULSE;
              end else begin
                seq_phase_next = PH_OFF;
              end
              retain = RETAIN_OFF_CODE;
            end
            flags_next[FL_PWR_REQ] = 1'b0;
          end
          if (flags_next[FL_RST_REQ]) begin
            if (powered) begin
              pins_next[PIN_RESET] = 1'b1; elapsed_next = '0;
              seq_phase_next = PH_RESET_HOLD;
            end
            flags_next[FL_RST_REQ] = 1'b0;
          end
        end
        PH_POWER_ON: begin
          flags_next[FL_WATCH] = 1'b0; flags_next[FL_COORD] = 1'b0;
          alert_mode_next = AL_UP; pattern_index_next = '0;
          pins_next[PIN_RESET] = 1'b1; pins_next[PIN_SUPPLY] = 1'b1;
          elapsed_next = '0; seq_phase_next = PH_WAIT_GOOD;
        end
        PH_WAIT_GOOD: begin
          if (tick.power_good) begin
            pins_next[PIN_RESET] = 1'b0; elapsed_next = '0;
            seq_phase_next = PH_RESET_HOLD; retain = RETAIN_ON_CODE;
            alert_mode_next = AL_ON; pattern_index_next = '0;
          end else begin
            elapsed_next = el_inc;
            if (el_inc >= cfg.power_good_timeout) begin
              seq_phase_next = PH_OFF; flags_next[FL_FAULT] = 1'b1;
            end
          end
        end
        PH_RESET_HOLD: begin
          elapsed_next = el_inc;
          if (el_inc >= cfg.reset_hold_ticks && !tick.store_busy) begin
            seq_phase_next = PH_MONITOR; powered_next = 1'b1;
            flags_next[FL_WATCH] = 1'b1; pins_next[PIN_RESET] = 1'b0;
          end
        end
        PH_OFF: begin
          flags_next[FL_WATCH] = 1'b0;
          pins_next[PIN_RESET] = 1'b1; pins_next[PIN_SUPPLY] = 1'b0;
          pins_next[PIN_REQ] = 1'b0;
          if (!tick.power_good && !tick.store_busy) begin
            seq_phase_next = PH_MONITOR; powered_next = 1'b0;
            flags_next[FL_PWR_REQ] = 1'b0; flags_next[FL_OVERRIDE] = 1'b0;
            flags_next[FL_COORD] = 1'b0;
            pattern_index_next = '0;
            if (flags_next[FL_FAULT]) begin
              flags_next[FL_FAULT] = 1'b0; alert_mode_next = AL_FAIL;
            end else begin
              alert_mode_next = AL_OFF;
            end
          end
        end
        default: begin
          elapsed_next = el_inc;
          if (el_inc >= cfg.host_pulse_ticks) begin
            pins_next[PIN_REQ] = 1'b0; seq_phase_next = PH_MONITOR;
          end
        end
      endcase
    end

    result.supply_enable = pins_next[PIN_SUPPLY];
    result.system_reset  = pins_next[PIN_RESET];
    result.led_on        = led;
    result.request_drive = pins_next[PIN_REQ];
    result.retain_write  = retain;
    result.fault_flag    = flags_next[FL_FAULT];
    result.is_powered    = powered_next;
    result.phase         = seq_phase_next;
  end

endmodule
`default_nettype wire

>>> rtl/atx_power_sequencer_unit.sv
// ----------------------------------------------------------------------------
// atx_power_sequencer_unit: ATX power sequencer, one tick per item
// Debounces buttons, sequences supply and reset, plays LED patterns.
// ----------------------------------------------------------------------------
// Usage:
//   tick_in carries one 10 ms tick of pin samples; result_out carries the pin
//   drives, retention write, fault, powered and phase after that tick.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Latency: a result is valid in the cycle after its tick's transfer.
// Throughput: one tick per cycle while result_out is not stalled. The state
//   update is a single pass of combinational logic into the state registers,
//   registered into one output register refilled in the cycle it is taken.
// Reset: rst clears all sequencer state to the start phase, empties the
//   output register and loads the register defaults.
// Stall: while a result waits untaken and the receiver holds ready low, no
//   new tick is taken; ticks held by the sender are not lost.
// ----------------------------------------------------------------------------
`default_nettype none
module atx_power_sequencer_unit
  import aps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  aps_stream_if.sink      tick_in,
  aps_stream_if.source    result_out,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    out_valid;
  logic    step;

  aps_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // A tick transfers when the output register is empty or being emptied.
  assign tick_in.ready = !out_valid || result_out.ready;
  assign step = tick_in.valid && tick_in.ready;

  aps_tick_core u_core (
    .clk(clk), .rst(rst), .step(step), .tick(tick_in.data), .cfg(cfg),
    .result(result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_in.ready) begin
      out_valid <= tick_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_out.data <= result;
    end
  end

  assign result_out.valid = out_valid;

endmodule
`default_nettype wire

>>> rtl/aps_checker.sv
// ----------------------------------------------------------------------------
// aps_checker: port-level checks of the power sequencer
// Watches the channels and flags broken ordering or inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none
module aps_checker
  import aps_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire result_t out_data
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A tick transfer yields a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after tick transfer");

  // Output space is free whenever nothing waits.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // The on code is written only on the way into reset hold.
  a_retain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.retain_write == RETAIN_ON_CODE |->
      out_data.phase == 3'(PH_RESET_HOLD) && out_data.supply_enable)
    else $error("on code written outside power-up");

endmodule

bind atx_power_sequencer_unit aps_checker u_aps_checker (
  .clk(clk), .rst(rst), .in_valid(tick_in.valid), .in_ready(tick_in.ready),
  .out_valid(result_out.valid), .out_ready(result_out.ready),
  .out_data(result_out.data)
);
`default_nettype wire
